// ===== sv/taus_pkg.sv =====
// Shared package for the taus88 generator and bucket draw unit.
// Holds action codes, register indexes, seeding constants and the generator step function.
// No dependencies.
`default_nettype none
package taus_pkg;
   localparam logic [1:0] ACT_DRAW  = 2'd0;
   localparam logic [1:0] ACT_SEED  = 2'd1;
   localparam logic [1:0] ACT_BELL  = 2'd2;

   localparam logic [0:0] REG_RANGE  = 1'b0;
   localparam logic [0:0] REG_SPREAD = 1'b1;

   localparam logic [31:0] SEED_MULT  = 32'd69069;
   localparam logic [31:0] SEED_START = 32'd53;
   localparam logic [31:0] MASK_ONE   = 32'd4294967294;
   localparam logic [31:0] MASK_TWO   = 32'd4294967288;
   localparam logic [31:0] MASK_THREE = 32'd4294967280;
   localparam logic [31:0] MIN_ONE    = 32'd1;
   localparam logic [31:0] MIN_TWO    = 32'd7;
   localparam logic [31:0] MIN_THREE  = 32'd15;

   typedef struct packed {
      logic [31:0] one;
      logic [31:0] two;
      logic [31:0] three;
   } words_type;

   function automatic words_type taus_step(input words_type w);
      words_type n;
      n.one   = ((w.one & MASK_ONE) << 12) ^ (((w.one << 13) ^ w.one) >> 19);
      n.two   = ((w.two & MASK_TWO) << 4) ^ (((w.two << 2) ^ w.two) >> 25);
      n.three = ((w.three & MASK_THREE) << 17) ^ (((w.three << 3) ^ w.three) >> 11);
      return n;
   endfunction

   function automatic logic [31:0] floor_fix(input logic [31:0] v, input logic [31:0] m);
      return (v < m) ? v + m : v;
   endfunction
endpackage
`default_nettype wire

// ===== sv/taus_divu.sv =====
// Shared restoring divider: 64-bit dividend by 33-bit divisor, one bit per cycle.
// Produces the remainder; depends on nothing else.
`default_nettype none
module taus_divu (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [32:0] divisor,
   output logic             done,
   output logic [32:0]      remainder
);
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] shifted;
   logic [33:0] diff;

   assign shifted = {rem_ff, quo_ff[63]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[33]) begin
            rem_in = diff[32:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[32:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// ===== sv/taus88_rng_with_gauss_draw_unit.sv =====
// Raw draw or unused action: the result is registered in the cycle after accept; a waiting
// result stalls input. Reseed: three seeding states, then WARMUP_STEPS steps, then a zero result.
// Bell draw: SUM_DRAWS summed draws, each reduced on the shared divider, then the average, with
// spread a deviation halved until it fits, then the final modulo (skipped if the range is 0).
// Reset is synchronous: it reloads the register defaults and reseeds with seed one,
// with the input stalled until the warm-up ends.
`default_nettype none
module taus88_rng_with_gauss_draw_unit
   import taus_pkg::*;
#(
   parameter int SUM_DRAWS    = 12,
   parameter int WARMUP_STEPS = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [31:0] req_seed_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_value,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int CW = $clog2(SUM_DRAWS + WARMUP_STEPS + 2);
   // average by reciprocal multiply, exact for 25-bit inputs and divisors up to 64
   localparam logic [31:0] RCP_MULT = 32'((64'd2147483648 + 64'(SUM_DRAWS) - 64'd1)
                                          / 64'(SUM_DRAWS));
   localparam logic [24:0] RCP_DIV  = 25'(SUM_DRAWS);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SEED1 = 4'd1;
   localparam logic [3:0] S_SEED2 = 4'd2;
   localparam logic [3:0] S_SEED3 = 4'd3;
   localparam logic [3:0] S_WARM  = 4'd4;
   localparam logic [3:0] S_SUMD  = 4'd5;
   localparam logic [3:0] S_SUMW  = 4'd6;
   localparam logic [3:0] S_AVGW  = 4'd7;
   localparam logic [3:0] S_MUL   = 4'd8;
   localparam logic [3:0] S_HALF  = 4'd9;
   localparam logic [3:0] S_MODW  = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;
   localparam logic [3:0] S_AVGS  = 4'd12;
   localparam logic [3:0] S_MODS  = 4'd13;
   localparam logic [3:0] S_AVGL  = 4'd14;

   words_type   w_ff, w_in;
   logic [3:0]  st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0] seed_ff, seed_in;
   logic [31:0] range_ff;
   logic [30:0] spread_ff;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] dev_ff, dev_in;
   logic [31:0] rnd_ff, rnd_in;
   logic        ov_ff, ov_in;
   logic [31:0] ov_data_ff, ov_data_in;
   logic        rst_seed_ff, rst_seed_in;
   logic [18:0] qhi_ff, qhi_in;
   logic [5:0]  rpart_ff, rpart_in;

   words_type   w_next;
   logic [31:0] draw;
   logic [31:0] mul_src;
   logic [31:0] mul_lo;
   logic [62:0] scaled;
   logic [63:0] trial;
   logic [24:0] rcp_src;
   logic [55:0] rcp_prod;
   logic [24:0] rcp_q;
   logic [24:0] rcp_qd;
   logic [24:0] rcp_r;

   logic        div_start;
   logic [63:0] div_dividend;
   logic [32:0] div_divisor;
   logic        div_done;
   logic [32:0] div_rem;

   taus_divu u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign w_next = taus_step(w_ff);
   assign draw   = w_next.one ^ w_next.two ^ w_next.three;
   assign mul_lo = mul_src * SEED_MULT;
   assign scaled = {32'd0, spread_ff} * {31'd0, rnd_ff};
   assign trial  = acc_ff + dev_ff;

   // two-digit long division by SUM_DRAWS: high 19 bits, then remainder with low 19 bits
   assign rcp_src  = (st_ff == S_AVGL) ? {rpart_ff, acc_ff[18:0]} : {6'd0, acc_ff[37:19]};
   assign rcp_prod = {31'd0, rcp_src} * {24'd0, RCP_MULT};
   assign rcp_q    = rcp_prod[55:31];
   assign rcp_qd   = rcp_q * RCP_DIV;
   assign rcp_r    = rcp_src - rcp_qd;

   always_comb begin
      mul_src = SEED_START;
      case (st_ff)
         S_SEED2: mul_src = w_ff.one;
         S_SEED3: mul_src = w_ff.two;
         default: mul_src = SEED_START;
      endcase
   end

   assign req_stall = (st_ff != S_IDLE) || ov_ff;

   always_comb begin
      w_in         = w_ff;
      st_in        = st_ff;
      cnt_in       = cnt_ff;
      seed_in      = seed_ff;
      acc_in       = acc_ff;
      dev_in       = dev_ff;
      rnd_in       = rnd_ff;
      ov_in        = ov_ff;
      ov_data_in   = ov_data_ff;
      rst_seed_in  = rst_seed_ff;
      qhi_in       = qhi_ff;
      rpart_in     = rpart_ff;
      div_start    = 1'b0;
      div_dividend = acc_ff;
      div_divisor  = {1'b0, range_ff} + 33'd1;

      if (ov_ff && !rsp_stall)
         ov_in = 1'b0;

      case (st_ff)
         S_IDLE: begin
            if (req_valid && !ov_ff) begin
               case (req_action)
                  ACT_DRAW: begin
                     w_in       = w_next;
                     ov_in      = 1'b1;
                     ov_data_in = draw;
                  end
                  ACT_SEED: begin
                     seed_in = req_seed_value;
                     st_in   = S_SEED1;
                  end
                  ACT_BELL: begin
                     acc_in = '0;
                     cnt_in = CW'(SUM_DRAWS);
                     st_in  = S_SUMD;
                  end
                  default: begin
                     ov_in      = 1'b1;
                     ov_data_in = '0;
                  end
               endcase
            end
         end
         S_SEED1: begin
            w_in.one = floor_fix(mul_lo ^ seed_ff, MIN_ONE);
            st_in    = S_SEED2;
         end
         S_SEED2: begin
            w_in.two = floor_fix(mul_lo ^ seed_ff, MIN_TWO);
            st_in    = S_SEED3;
         end
         S_SEED3: begin
            w_in.three = floor_fix(mul_lo ^ seed_ff, MIN_THREE);
            cnt_in     = CW'(WARMUP_STEPS);
            st_in      = S_WARM;
         end
         S_WARM: begin
            if (cnt_ff == '0) begin
               st_in = S_IDLE;
               if (rst_seed_ff)
                  rst_seed_in = 1'b0;
               else begin
                  ov_in      = 1'b1;
                  ov_data_in = '0;
               end
            end else begin
               w_in   = w_next;
               cnt_in = cnt_ff - CW'(1);
            end
         end
         S_SUMD: begin
            w_in         = w_next;
            div_start    = 1'b1;
            div_dividend = {32'd0, draw};
            st_in        = S_SUMW;
         end
         S_SUMW: begin
            if (div_done) begin
               acc_in = acc_ff + {31'd0, div_rem};
               cnt_in = cnt_ff - CW'(1);
               st_in  = (cnt_ff == CW'(1)) ? S_AVGS : S_SUMD;
            end
         end
         S_AVGS: begin
            acc_in = acc_ff + 64'(SUM_DRAWS - 1);
            st_in  = S_AVGW;
         end
         S_AVGW: begin
            qhi_in   = rcp_q[18:0];
            rpart_in = rcp_r[5:0];
            st_in    = S_AVGL;
         end
         S_AVGL: begin
            acc_in = {26'd0, qhi_ff, rcp_q[18:0]};
            if (spread_ff != '0) begin
               w_in   = w_next;
               rnd_in = draw;
               st_in  = S_MUL;
            end else
               st_in = S_MODS;
         end
         S_MUL: begin
            dev_in = {33'd0, scaled[62:32]} - {34'd0, spread_ff[30:1]};
            st_in  = S_HALF;
         end
         S_HALF: begin
            // halve toward zero until the deviation is zero or the sum drops below the range
            if (dev_ff != '0 && trial >= {32'd0, range_ff})
               dev_in = $signed(dev_ff) / 64'sd2;
            else begin
               acc_in = trial;
               st_in  = S_MODS;
            end
         end
         S_MODS: begin
            if (range_ff == '0) begin
               ov_in      = 1'b1;
               ov_data_in = '0;
               st_in      = S_IDLE;
            end else begin
               div_start   = 1'b1;
               div_divisor = {1'b0, range_ff};
               st_in       = S_MODW;
            end
         end
         S_MODW: begin
            div_divisor = {1'b0, range_ff};
            if (div_done) begin
               ov_in      = 1'b1;
               ov_data_in = div_rem[31:0];
               st_in      = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= S_SEED1;
         seed_ff     <= 32'd1;
         ov_ff       <= 1'b0;
         rst_seed_ff <= 1'b1;
         range_ff    <= 32'd1;
         spread_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         st_ff       <= st_in;
         seed_ff     <= seed_in;
         ov_ff       <= ov_in;
         rst_seed_ff <= rst_seed_in;
         cnt_ff      <= cnt_in;
         if (csr_write) begin
            if (csr_index == REG_RANGE)
               range_ff <= csr_data;
            else if (csr_index == REG_SPREAD)
               spread_ff <= csr_data[30:0];
         end
      end
      w_ff       <= w_in;
      acc_ff     <= acc_in;
      dev_ff     <= dev_in;
      rnd_ff     <= rnd_in;
      ov_data_ff <= ov_data_in;
      qhi_ff     <= qhi_in;
      rpart_ff   <= rpart_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_value = ov_data_ff;
endmodule
`default_nettype wire

// ===== tb/taus88_rng_with_gauss_draw_unit_tb.sv =====
// Testbench for the taus88 generator with bell-shaped bucket draw.
// Predicts every result in-bench and compares it with the DUT output.
// Depends on taus_pkg and taus88_rng_with_gauss_draw_unit.
`default_nettype none
module taus88_rng_with_gauss_draw_unit_tb;
   import taus_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SUM_DRAWS    = 12;
   localparam int WARMUP_STEPS = 6;
   localparam longint CYCLE_LIMIT = 64'd10000000;
   localparam logic [1:0] ACT_SPARE  = 2'd3;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [31:0] req_seed_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [31:0] rsp_value;
   logic        csr_write = 0;
   logic [0:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   taus88_rng_with_gauss_draw_unit #(.SUM_DRAWS(SUM_DRAWS), .WARMUP_STEPS(WARMUP_STEPS)) dut (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_seed_value,
      .rsp_valid, .rsp_stall, .rsp_value, .csr_write, .csr_index, .csr_data
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // predictor state
   logic [31:0] gen_a, gen_b, gen_c;
   logic [31:0] buckets;
   logic [30:0] dev_width;
   logic [31:0] value_queue[$];
   int          mismatches = 0;
   int          checked = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   longint      cycles = 0;

   function automatic logic [31:0] gen_advance();
      gen_a = ((gen_a & 32'hFFFF_FFFE) << 12) ^ (((gen_a << 13) ^ gen_a) >> 19);
      gen_b = ((gen_b & 32'hFFFF_FFF8) << 4) ^ (((gen_b << 2) ^ gen_b) >> 25);
      gen_c = ((gen_c & 32'hFFFF_FFF0) << 17) ^ (((gen_c << 3) ^ gen_c) >> 11);
      return gen_a ^ gen_b ^ gen_c;
   endfunction

   function automatic logic [31:0] raise_min(logic [31:0] v, logic [31:0] m);
      return (v < m) ? v + m : v;
   endfunction

   function automatic void gen_reseed(logic [31:0] s);
      logic [31:0] t;
      gen_a = raise_min((32'd53 * 32'd69069) ^ s, 32'd1);
      gen_b = raise_min((gen_a * 32'd69069) ^ s, 32'd7);
      gen_c = raise_min((gen_b * 32'd69069) ^ s, 32'd15);
      for (int k = 0; k < WARMUP_STEPS; k++) t = gen_advance();
   endfunction

   function automatic logic [31:0] bucket_draw();
      logic [63:0] acc, modulus, scaled;
      longint      dev;
      acc = 0;
      modulus = {32'd0, buckets} + 64'd1;
      for (int k = 0; k < SUM_DRAWS; k++) acc += {32'd0, gen_advance()} % modulus;
      acc = (acc + 64'(SUM_DRAWS) - 64'd1) / 64'(SUM_DRAWS);
      if (dev_width != 0) begin
         scaled = ({33'd0, dev_width} * {32'd0, gen_advance()}) >> 32;
         dev = longint'(scaled) - longint'({33'd0, dev_width} >> 1);
         while (dev != 0 && (acc + 64'(dev)) >= {32'd0, buckets}) dev = dev / 2;
         acc += 64'(dev);
      end
      if (buckets == 0) return 32'd0;
      return 32'(acc % {32'd0, buckets});
   endfunction

   function automatic logic [31:0] predict_value(logic [1:0] act, logic [31:0] s);
      case (act)
         ACT_DRAW: return gen_advance();
         ACT_SEED: begin
            gen_reseed(s);
            return 32'd0;
         end
         ACT_BELL: return bucket_draw();
         default: return 32'd0;
      endcase
   endfunction

   // receiver: random stall and result check
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (value_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction value=%h", rsp_value);
         end else begin
            logic [31:0] want;
            want = value_queue.pop_front();
            checked++;
            if (want !== rsp_value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("value mismatch: expected %h actual %h", want, rsp_value);
            end
         end
      end
   end

   // valid stays up after acceptance until the next idle cycle or transaction
   task automatic send_item(logic [1:0] act, logic [31:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_seed_value <= s;
      do @(posedge clock); while (req_stall);
      value_queue.push_back(predict_value(act, s));
   endtask

   task automatic drain();
      req_valid <= 0;
      while (value_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [31:0] d);
      drain();
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      csr_write <= 0;
      if (idx == REG_RANGE) buckets = d;
      else dev_width = d[30:0];
   endtask

   task automatic test_directed();
      send_item(ACT_DRAW, 32'd0);
      send_item(ACT_BELL, 32'hFFFF_FFFF);
      send_item(ACT_SPARE, 32'h1234_5678);
      send_item(ACT_DRAW, 32'd0);
      send_item(ACT_SEED, 32'd0);
      send_item(ACT_DRAW, 32'd0);
      send_item(ACT_SEED, 32'hFFFF_FFFF);
      send_item(ACT_DRAW, 32'd0);
      send_item(ACT_SEED, 32'd53 * 32'd69069);  // first word hits the minimum fix
      send_item(ACT_DRAW, 32'd0);
      write_reg(REG_RANGE, 32'd0);              // empty range
      send_item(ACT_BELL, 32'd0);
      write_reg(REG_SPREAD, 32'h7FFF_FFFF);
      send_item(ACT_BELL, 32'd0);
      write_reg(REG_RANGE, 32'hFFFF_FFFF);
      send_item(ACT_BELL, 32'd0);
      send_item(ACT_BELL, 32'd0);
      write_reg(REG_RANGE, 32'd3);              // deviation mostly exhausted
      send_item(ACT_BELL, 32'd0);
      send_item(ACT_BELL, 32'd0);
      write_reg(REG_SPREAD, 32'd1);
      send_item(ACT_BELL, 32'd0);
      send_item(ACT_SPARE, 32'hFFFF_FFFF);
   endtask

   task automatic test_random(int count);
      logic [1:0] act;
      for (int n = 0; n < count; n++) begin
         if (n % 160 == 0) begin
            write_reg(REG_RANGE, ($urandom_range(3) == 0) ? $urandom : $urandom_range(40));
            write_reg(REG_SPREAD, ($urandom_range(2) == 0) ? 32'd0 :
                      ($urandom_range(1) ? {1'b0, 31'($urandom)} : $urandom_range(64)));
         end
         case ($urandom_range(19))
            0, 1: act = ACT_SEED;
            2, 3, 4: act = ACT_BELL;
            5: act = ACT_SPARE;
            default: act = ACT_DRAW;
         endcase
         send_item(act, $urandom);
      end
      drain();  // sender holds off until all results are in
   endtask

   initial begin
      gen_reseed(32'd1);
      buckets = 32'd1;
      dev_width = '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      send_idle_pct = 31; recv_idle_pct = 58;
      test_directed();
      test_random(650);
      send_idle_pct = 58; recv_idle_pct = 31;
      test_random(650);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(650);
      drain();
      $display("checked %0d transactions over draws, reseeds and bell draws", checked);
      $display("range and spread swept including zero and full-width settings");
      if (mismatches == 0 && value_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
